// ===== hw/rtl/uff_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Ultrasonic frame filter package
// Shared types and fixed constants for the frame checker and range filter.
// ----------------------------------------------------------------------------
package uff_pkg;

	// Configuration port layout
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 9;

	// Register indexes
	localparam logic [CFG_IDX_W-1:0] REG_ALPHA  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MARKER = 2'd1;

	// Register reset values
	localparam logic [8:0] ALPHA_RESET  = 9'd128;
	localparam logic [7:0] MARKER_RESET = 8'hFF;

	// Filter weight of one, and the shift that divides by it
	localparam logic [8:0] ALPHA_ONE   = 9'd256;
	localparam int         ALPHA_SHIFT = 8;
	localparam int         ALPHA_HALF  = 128;

	// Distance handling
	localparam logic [15:0] FAILSAFE_MM  = 16'd6000;
	localparam logic [11:0] RANGE_MIN_MM = 12'd200;
	localparam logic [11:0] RANGE_MAX_MM = 12'd4000;

	// Queue depths (powers of two)
	localparam int FRM_DEPTH = 4;
	localparam int RES_DEPTH = 4;

	// A checked frame on its way from the front to the back
	typedef struct packed {
		logic        ch;
		logic        fail;
		logic [15:0] dist_mm;
	} frame_t;

	// One result beat
	typedef struct packed {
		logic        ch;
		logic [11:0] range_mm;
		logic        fail;
	} result_t;

endpackage

// ===== hw/rtl/uff_fifo.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Small register queue
// First-in first-out buffer of flip-flops with full and empty flags.
// ----------------------------------------------------------------------------
module uff_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             wr_en,
	input  logic [WIDTH-1:0] wr_data,
	output logic             full,
	input  logic             rd_en,
	output logic [WIDTH-1:0] rd_data,
	output logic             empty
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_wr;
	logic             do_rd;

	assign full    = (count_q == CNT_W'(DEPTH));
	assign empty   = (count_q == '0);
	assign do_wr   = wr_en && !full;
	assign do_rd   = rd_en && !empty;
	assign rd_data = mem_q[rd_ptr_q];

	// Storage is written without reset.
	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	// Pointers wrap at the depth; the count tracks occupancy.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_wr && !do_rd) begin
				count_q <= count_q + 1'b1;
			end else if (do_rd && !do_wr) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// ===== hw/rtl/uff_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Ultrasonic frame filter front end
// Collects four-byte frames, checks start byte and checksum, and queues
// the distance of every good frame with its fail-safe substitution applied.
// ----------------------------------------------------------------------------
module uff_front #(
	parameter int CHANNELS = 2
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic [7:0]      start_marker,
	input  logic            push,
	input  logic            channel,
	input  logic            frame_start,
	input  logic [7:0]      rx_byte,
	input  logic            frm_full,
	output logic            frm_push,
	output uff_pkg::frame_t frm_data
);

	// Byte position codes
	localparam logic [1:0] POS_IDLE = 2'd0;
	localparam logic [1:0] POS_HIGH = 2'd1;
	localparam logic [1:0] POS_LOW  = 2'd2;
	localparam logic [1:0] POS_SUM  = 2'd3;

	logic [1:0]  pos_q;
	logic        header_ok_q;
	logic [7:0]  high_q;
	logic [7:0]  low_q;
	logic        accept;
	logic [7:0]  sum;
	logic        ch_ok;
	logic [15:0] raw_dist;

	assign accept   = push && !frm_full;
	assign sum      = start_marker + high_q + low_q;
	assign ch_ok    = (int'(channel) < CHANNELS);
	assign raw_dist = {high_q, low_q};

	// A checksum beat of a good frame goes to the queue.
	assign frm_push = accept && !frame_start && (pos_q == POS_SUM) && header_ok_q &&
		(rx_byte == sum) && ch_ok;

	// A zero distance is replaced by the fail-safe value.
	always_comb begin
		frm_data.ch      = channel;
		frm_data.fail    = (raw_dist == '0);
		frm_data.dist_mm = (raw_dist == '0) ? uff_pkg::FAILSAFE_MM : raw_dist;
	end

	// Frame collection; a frame start always restarts the frame.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q       <= POS_IDLE;
			header_ok_q <= 1'b0;
			high_q      <= '0;
			low_q       <= '0;
		end else if (accept) begin
			if (frame_start) begin
				header_ok_q <= (rx_byte == start_marker);
				pos_q       <= POS_HIGH;
			end else begin
				case (pos_q)
					POS_HIGH: begin
						high_q <= rx_byte;
						pos_q  <= POS_LOW;
					end
					POS_LOW: begin
						low_q <= rx_byte;
						pos_q <= POS_SUM;
					end
					default: begin
						pos_q <= POS_IDLE;
					end
				endcase
			end
		end
	end

endmodule

// ===== hw/rtl/uff_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Ultrasonic frame filter back end
// Per-channel moving-average filter: a multiply stage, then an update stage
// that writes the filter state and queues the clamped range.
// ----------------------------------------------------------------------------
module uff_back #(
	parameter int CHANNELS  = 2,
	parameter int FRAC_BITS = 8
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic [8:0]       alpha,
	input  logic             frm_empty,
	input  uff_pkg::frame_t  frm_data,
	output logic             frm_pop,
	input  logic             res_full,
	output logic             res_push,
	output uff_pkg::result_t res_data
);

	localparam int FW    = 16 + FRAC_BITS;
	localparam int DW    = FW + 1;
	localparam int PW    = DW + 10;
	localparam int IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
	localparam logic signed [PW-1:0] ROUND = PW'(uff_pkg::ALPHA_HALF);

	logic [FW-1:0]           filt_q [CHANNELS];
	logic                    issue;
	logic [IDX_W-1:0]        rd_idx;
	logic [FW-1:0]           old_val;
	logic [FW-1:0]           sample;
	logic signed [DW-1:0]    diff;
	logic signed [PW-1:0]    prod;

	logic                    valid_s1;
	logic                    ch_s1;
	logic                    fail_s1;
	logic [FW-1:0]           old_s1;
	logic signed [PW-1:0]    prod_s1;

	logic signed [PW-1:0]    rnd_s2;
	logic signed [PW-1:0]    sum_s2;
	logic [FW-1:0]           f_new;
	logic [15:0]             mm;
	logic [11:0]             range_clamped;
	logic [IDX_W-1:0]        wr_idx;

	// One frame in flight; the result queue cannot fill while it is.
	assign issue   = !frm_empty && !valid_s1 && !res_full;
	assign frm_pop = issue;

	// Stage 1: weighted difference between new sample and old filter value.
	assign rd_idx  = IDX_W'(frm_data.ch);
	assign old_val = filt_q[rd_idx];
	assign sample  = FW'(frm_data.dist_mm) << FRAC_BITS;
	assign diff    = $signed({1'b0, sample}) - $signed({1'b0, old_val});
	assign prod    = $signed({1'b0, alpha}) * diff;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= issue;
		end
	end

	always_ff @(posedge clk) begin
		if (issue) begin
			ch_s1   <= frm_data.ch;
			fail_s1 <= frm_data.fail;
			old_s1  <= old_val;
			prod_s1 <= prod;
		end
	end

	// Stage 2: rounded divide by the weight of one and add to the old value.
	assign rnd_s2 = prod_s1 + ROUND;
	assign sum_s2 = PW'($signed({1'b0, old_s1})) + (rnd_s2 >>> uff_pkg::ALPHA_SHIFT);
	assign f_new  = sum_s2[FW-1:0];
	assign mm     = f_new[FW-1:FRAC_BITS];
	assign wr_idx = IDX_W'(ch_s1);

	// Clamp the integer millimetres to the reporting range.
	always_comb begin
		if (mm < 16'(uff_pkg::RANGE_MIN_MM)) begin
			range_clamped = uff_pkg::RANGE_MIN_MM;
		end else if (mm > 16'(uff_pkg::RANGE_MAX_MM)) begin
			range_clamped = uff_pkg::RANGE_MAX_MM;
		end else begin
			range_clamped = mm[11:0];
		end
	end

	assign res_push          = valid_s1;
	assign res_data.ch       = ch_s1;
	assign res_data.range_mm = range_clamped;
	assign res_data.fail     = fail_s1;

	// Filter state, cleared at reset.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < CHANNELS; i++) begin
				filt_q[i] <= '0;
			end
		end else if (valid_s1) begin
			filt_q[wr_idx] <= f_new;
		end
	end

	// A frame never follows another into stage 1 directly.
	a_single_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 |=> !valid_s1)
		else $error("back end issued while a frame was in flight");

	// The result queue always has room for a finished frame.
	a_room_for_result: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 |-> !res_full)
		else $error("result queue full when a result was ready");

	// The reported range lies within the clamp limits.
	a_range_clamped: assert property (@(posedge clk) disable iff (!arst_n)
		res_push |-> (res_data.range_mm >= uff_pkg::RANGE_MIN_MM &&
			res_data.range_mm <= uff_pkg::RANGE_MAX_MM))
		else $error("reported range outside limits");

endmodule

// ===== hw/rtl/ultrasonic_frame_filter_top.sv =====
`timescale 1ns / 1ps
// A checksum beat passes the frame queue and filter stage 1 before empty goes low.
// Throughput: one byte beat per cycle; the filter holds one frame at a time and a frame is
// at least four beats long, so the input only stalls on a full result queue.
// Reset: arst_n clears frame collection, both filters to zero, the queues and the
// registers to alpha 128 and start marker 0xFF, all at once with no clearing pass.
// ----------------------------------------------------------------------------
// Ultrasonic frame filter
// Frame checker and per-channel moving-average range filter with queue ports.
// ----------------------------------------------------------------------------
module ultrasonic_frame_filter_top #(
	parameter int CHANNELS  = 2,
	parameter int FRAC_BITS = 8
) (
	input  logic                           clk,
	input  logic                           arst_n,
	// Configuration
	input  logic                           cfg_we,
	input  logic [uff_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [uff_pkg::CFG_DATA_W-1:0] cfg_wdata,
	// Byte input
	input  logic                           push,
	output logic                           full,
	input  logic                           channel,
	input  logic                           frame_start,
	input  logic [7:0]                     rx_byte,
	// Results
	output logic                           empty,
	input  logic                           pop,
	output logic                           out_channel,
	output logic [11:0]                    range_mm,
	output logic                           fail_substituted
);

	logic [8:0]       alpha_q;
	logic [7:0]       marker_q;

	logic             frm_push;
	uff_pkg::frame_t  frm_wdata;
	logic             frm_full;
	logic             frm_pop;
	uff_pkg::frame_t  frm_rdata;
	logic             frm_empty;

	logic             res_push;
	uff_pkg::result_t res_wdata;
	logic             res_full;
	uff_pkg::result_t res_rdata;

	// Configuration registers; alpha saturates at one when written.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			alpha_q  <= uff_pkg::ALPHA_RESET;
			marker_q <= uff_pkg::MARKER_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				uff_pkg::REG_ALPHA: begin
					alpha_q <= (cfg_wdata > uff_pkg::ALPHA_ONE) ? uff_pkg::ALPHA_ONE
						: cfg_wdata;
				end
				uff_pkg::REG_MARKER: begin
					marker_q <= cfg_wdata[7:0];
				end
				default: begin
				end
			endcase
		end
	end

	assign full = frm_full;

	uff_front #(
		.CHANNELS(CHANNELS)
	) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.start_marker(marker_q),
		.push(push),
		.channel(channel),
		.frame_start(frame_start),
		.rx_byte(rx_byte),
		.frm_full(frm_full),
		.frm_push(frm_push),
		.frm_data(frm_wdata)
	);

	// Queue of checked frames between front and back.
	uff_fifo #(
		.WIDTH($bits(uff_pkg::frame_t)),
		.DEPTH(uff_pkg::FRM_DEPTH)
	) u_frm_fifo (
		.clk(clk),
		.arst_n(arst_n),
		.wr_en(frm_push),
		.wr_data(frm_wdata),
		.full(frm_full),
		.rd_en(frm_pop),
		.rd_data(frm_rdata),
		.empty(frm_empty)
	);

	uff_back #(
		.CHANNELS(CHANNELS),
		.FRAC_BITS(FRAC_BITS)
	) u_back (
		.clk(clk),
		.arst_n(arst_n),
		.alpha(alpha_q),
		.frm_empty(frm_empty),
		.frm_data(frm_rdata),
		.frm_pop(frm_pop),
		.res_full(res_full),
		.res_push(res_push),
		.res_data(res_wdata)
	);

	// Result queue facing the consumer.
	uff_fifo #(
		.WIDTH($bits(uff_pkg::result_t)),
		.DEPTH(uff_pkg::RES_DEPTH)
	) u_res_fifo (
		.clk(clk),
		.arst_n(arst_n),
		.wr_en(res_push),
		.wr_data(res_wdata),
		.full(res_full),
		.rd_en(pop),
		.rd_data(res_rdata),
		.empty(empty)
	);

	assign out_channel      = res_rdata.ch;
	assign range_mm         = res_rdata.range_mm;
	assign fail_substituted = res_rdata.fail;

endmodule

// ===== bench/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Ultrasonic frame filter testbench
// Sends byte beats through the frame checker and compares every range beat
// with a local model of the frame collection and the per-channel filter.
// Register settings change between phases while the block is idle.
// ----------------------------------------------------------------------------
module tb_top;

	localparam int CHANNELS  = 2;
	localparam int FRAC_BITS = 8;

	// Indexes beyond the register list; writes to them must be ignored
	localparam logic [uff_pkg::CFG_IDX_W-1:0] REG_SPARE_A = 2'd2;
	localparam logic [uff_pkg::CFG_IDX_W-1:0] REG_SPARE_B = 2'd3;

	// Frame collection positions
	localparam logic [2:0] POS_IDLE = 3'd0;
	localparam logic [2:0] POS_HIGH = 3'd1;
	localparam logic [2:0] POS_LOW  = 3'd2;
	localparam logic [2:0] POS_SUM  = 3'd3;

	localparam int TARGET_BYTES  = 1750;
	localparam int PHASE_BYTES   = 250;
	localparam int SETTLE_CYCLES = 6;

	logic                           clk;
	logic                           arst_n    = 1'b0;
	logic                           cfg_we    = 1'b0;
	logic [uff_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
	logic [uff_pkg::CFG_DATA_W-1:0] cfg_wdata = '0;
	logic                           push        = 1'b0;
	logic                           full;
	logic                           channel     = 1'b0;
	logic                           frame_start = 1'b0;
	logic [7:0]                     rx_byte     = 8'h00;
	logic                           empty;
	logic                           pop         = 1'b0;
	logic                           out_channel;
	logic [11:0]                    range_mm;
	logic                           fail_substituted;

	// Model of the block: registers, frame collection and filter accumulators
	logic [8:0]            cur_alpha  = uff_pkg::ALPHA_RESET;
	logic [7:0]            cur_marker = uff_pkg::MARKER_RESET;
	logic [2:0]            frm_pos    = POS_IDLE;
	logic                  frm_hdr_ok = 1'b0;
	logic [7:0]            frm_hi     = 8'h00;
	logic [7:0]            frm_lo     = 8'h00;
	logic [15+FRAC_BITS:0] ema_acc [CHANNELS] = '{default: '0};

	uff_pkg::result_t ranges_due [$];

	int fail_count      = 0;
	int results_checked = 0;
	int bytes_used      = 0;
	int frames_passed   = 0;
	int burst_left      = 0;
	int pop_left        = 0;

	ultrasonic_frame_filter_top #(
		.CHANNELS (CHANNELS),
		.FRAC_BITS(FRAC_BITS)
	) u_dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_we          (cfg_we),
		.cfg_index       (cfg_index),
		.cfg_wdata       (cfg_wdata),
		.push            (push),
		.full            (full),
		.channel         (channel),
		.frame_start     (frame_start),
		.rx_byte         (rx_byte),
		.empty           (empty),
		.pop             (pop),
		.out_channel     (out_channel),
		.range_mm        (range_mm),
		.fail_substituted(fail_substituted)
	);

	// Clock
	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// Hard limit on the run time
	initial begin
		#5_000_000;
		$display("** ultrasonic_frame_filter_top: FAILED **");
		$finish;
	end

	// Applies one accepted byte beat to the model and queues any range it yields.
	task automatic track_rx_byte(input logic ch, input logic fs, input logic [7:0] b);
		logic [7:0]       sum;
		logic [15:0]      raw_dist;
		logic             fail;
		logic [63:0]      a;
		logic [63:0]      acc;
		logic [63:0]      mm;
		uff_pkg::result_t res;
		if (fs) begin
			frm_hdr_ok = (b == cur_marker);
			frm_pos    = POS_HIGH;
			bytes_used++;
			return;
		end
		case (frm_pos)
			POS_HIGH: begin
				frm_hi  = b;
				frm_pos = POS_LOW;
				bytes_used++;
			end
			POS_LOW: begin
				frm_lo  = b;
				frm_pos = POS_SUM;
				bytes_used++;
			end
			POS_SUM: begin
				frm_pos = POS_IDLE;
				bytes_used++;
				sum = cur_marker + frm_hi + frm_lo;
				if (frm_hdr_ok && b == sum && int'(ch) < CHANNELS) begin
					raw_dist = {frm_hi, frm_lo};
					fail = 1'b0;
					if (raw_dist == 16'd0) begin
						raw_dist = uff_pkg::FAILSAFE_MM;
						fail = 1'b1;
					end
					// Alpha above one saturates to one
					a   = (cur_alpha > uff_pkg::ALPHA_ONE) ? 64'(uff_pkg::ALPHA_ONE)
						: 64'(cur_alpha);
					acc = (a * (64'(raw_dist) << FRAC_BITS)
						+ (64'(uff_pkg::ALPHA_ONE) - a) * 64'(ema_acc[ch])
						+ 64'(uff_pkg::ALPHA_HALF)) >> uff_pkg::ALPHA_SHIFT;
					ema_acc[ch] = acc[15+FRAC_BITS:0];
					mm = acc >> FRAC_BITS;
					if (mm < 64'(uff_pkg::RANGE_MIN_MM))
						mm = 64'(uff_pkg::RANGE_MIN_MM);
					if (mm > 64'(uff_pkg::RANGE_MAX_MM))
						mm = 64'(uff_pkg::RANGE_MAX_MM);
					res.ch       = ch;
					res.range_mm = mm[11:0];
					res.fail     = fail;
					ranges_due.push_back(res);
					frames_passed++;
				end
			end
			default: begin
				// A byte with no frame start while idle is ignored
				frm_pos = POS_IDLE;
			end
		endcase
	endtask

	// Sends one byte beat, with bursts and random gaps between them.
	task automatic send_byte(input logic ch, input logic fs, input logic [7:0] b);
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 9);
			if (gap != 0) begin
				push <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
				: $urandom_range(1, 24);
		end
		burst_left--;
		push        <= 1'b1;
		channel     <= ch;
		frame_start <= fs;
		rx_byte     <= b;
		do
			@(posedge clk);
		while (full);
		track_rx_byte(ch, fs, b);
	endtask

	// Sends a four-byte frame; bit i of chs is the channel of byte i.
	task automatic send_frame(input logic [3:0] chs, input logic [7:0] head,
		input logic [7:0] hi, input logic [7:0] lo, input logic [7:0] ck);
		send_byte(chs[0], 1'b1, head);
		send_byte(chs[1], 1'b0, hi);
		send_byte(chs[2], 1'b0, lo);
		send_byte(chs[3], 1'b0, ck);
	endtask

	function automatic logic [7:0] checksum_for(input logic [7:0] hi, input logic [7:0] lo);
		logic [7:0] s;
		s = cur_marker + hi + lo;
		return s;
	endfunction

	// Writes a register once the block has drained and settled.
	task automatic write_reg(input logic [uff_pkg::CFG_IDX_W-1:0] idx,
		input logic [uff_pkg::CFG_DATA_W-1:0] val);
		push <= 1'b0;
		while (ranges_due.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == uff_pkg::REG_ALPHA)
			cur_alpha = val;
		else if (idx == uff_pkg::REG_MARKER)
			cur_marker = val[7:0];
	endtask

	function automatic logic [15:0] pick_distance();
		case ($urandom_range(0, 9))
			0:       return 16'd0;
			1:       return 16'hFFFF;
			2, 3:    return 16'($urandom_range(1, 300));
			4, 5, 6: return 16'($urandom_range(150, 4200));
			default: return 16'($urandom());
		endcase
	endfunction

	// Frame handling under the reset settings: stray bytes, restarts, drops.
	task automatic test_frame_basics();
		// Stray byte while idle
		send_byte(1'b0, 1'b0, 8'h5A);
		// Wrong start byte, abandoned by a restart in mid-frame
		send_byte(1'b1, 1'b1, 8'h00);
		send_byte(1'b1, 1'b0, 8'h12);
		// Mixed channels: the checksum beat picks channel 0; largest distance
		send_frame(4'b0011, cur_marker, 8'hFF, 8'hFF, checksum_for(8'hFF, 8'hFF));
		// Zero distance is replaced by the failsafe value
		send_frame(4'b1111, cur_marker, 8'h00, 8'h00, checksum_for(8'h00, 8'h00));
		// Bad checksum
		send_frame(4'b0000, cur_marker, 8'h01, 8'h2C, checksum_for(8'h01, 8'h2C) ^ 8'h01);
	endtask

	// Alpha at zero and above one, start marker at zero, writes to spare indexes.
	task automatic test_register_extremes();
		write_reg(uff_pkg::REG_ALPHA, 9'd0);
		send_frame(4'b0000, cur_marker, 8'h03, 8'hE8, checksum_for(8'h03, 8'hE8));
		write_reg(uff_pkg::REG_ALPHA, 9'h1FF);
		write_reg(uff_pkg::REG_MARKER, 9'h000);
		send_frame(4'b1111, cur_marker, 8'h00, 8'h96, checksum_for(8'h00, 8'h96));
		write_reg(REG_SPARE_A, 9'h1FF);
		write_reg(REG_SPARE_B, 9'h0AA);
		send_frame(4'b0000, cur_marker, 8'h0F, 8'hA0, checksum_for(8'h0F, 8'hA0));
	endtask

	// Mostly well-formed frames with random content, plus broken frames and noise.
	task automatic test_random_traffic();
		int          phase;
		int          next_phase;
		int          goal;
		int          kind;
		logic        c;
		logic [3:0]  chs;
		logic [15:0] d;
		logic [7:0]  head;
		logic [7:0]  ck;
		phase      = 0;
		goal       = bytes_used + TARGET_BYTES;
		next_phase = bytes_used;
		while (bytes_used < goal) begin
			// New settings at the start of each phase
			if (bytes_used >= next_phase) begin
				case (phase)
					0: begin
						write_reg(uff_pkg::REG_ALPHA, 9'd0);
						write_reg(uff_pkg::REG_MARKER, 9'h000);
					end
					1: begin
						write_reg(uff_pkg::REG_ALPHA, uff_pkg::ALPHA_ONE);
						write_reg(uff_pkg::REG_MARKER, 9'h0FF);
					end
					2: begin
						write_reg(uff_pkg::REG_ALPHA, 9'h1FF);
						write_reg(uff_pkg::REG_MARKER, 9'($urandom_range(0, 255)));
					end
					3: begin
						write_reg(uff_pkg::REG_ALPHA, 9'd1);
						write_reg(REG_SPARE_A, 9'($urandom_range(0, 511)));
					end
					default: begin
						write_reg(uff_pkg::REG_ALPHA, 9'($urandom_range(0, 511)));
						write_reg(uff_pkg::REG_MARKER, 9'($urandom_range(0, 255)));
					end
				endcase
				phase++;
				next_phase = bytes_used + PHASE_BYTES;
			end
			c    = 1'($urandom_range(0, 1));
			chs  = {4{c}};
			if ($urandom_range(0, 9) == 0)
				chs = 4'($urandom());
			d    = pick_distance();
			head = cur_marker;
			ck   = checksum_for(d[15:8], d[7:0]);
			kind = $urandom_range(0, 19);
			if (kind == 0) begin
				// Start byte that most likely misses the marker
				head = 8'($urandom());
				send_frame(chs, head, d[15:8], d[7:0], ck);
			end else if (kind == 1) begin
				ck = ck ^ 8'($urandom_range(1, 255));
				send_frame(chs, head, d[15:8], d[7:0], ck);
			end else if (kind == 2) begin
				// Truncated frame; the next frame start abandons it
				send_byte(chs[0], 1'b1, head);
				if ($urandom_range(0, 1) == 1)
					send_byte(chs[1], 1'b0, d[15:8]);
				if ($urandom_range(0, 1) == 1)
					send_byte(chs[2], 1'b0, d[7:0]);
			end else if (kind == 3) begin
				send_byte(c, 1'b0, 8'($urandom()));
			end else if (kind == 4) begin
				send_byte(c, 1'($urandom_range(0, 1)), 8'($urandom()));
			end else begin
				send_frame(chs, head, d[15:8], d[7:0], ck);
			end
		end
	endtask

	// Receiver: pops in runs and stalls in runs of its own
	always @(posedge clk) begin
		if (pop_left > 0) begin
			pop_left--;
		end else if (pop) begin
			pop <= 1'b0;
			pop_left = $urandom_range(0, 11);
		end else begin
			pop <= 1'b1;
			pop_left = ($urandom_range(0, 5) == 0) ? $urandom_range(80, 250)
				: $urandom_range(0, 20);
		end
	end

	// Compares each accepted result beat with the oldest expected range
	always @(posedge clk) begin
		uff_pkg::result_t want;
		if (arst_n && pop && !empty) begin
			if (ranges_due.size() == 0) begin
				$error("unexpected result: out_channel %0d, range_mm %0d, fail_substituted %0d",
					out_channel, range_mm, fail_substituted);
				fail_count++;
			end else begin
				want = ranges_due.pop_front();
				results_checked++;
				if (out_channel !== want.ch) begin
					$error("out_channel: expected %0d, actual %0d", want.ch, out_channel);
					fail_count++;
				end
				if (range_mm !== want.range_mm) begin
					$error("range_mm: expected %0d, actual %0d", want.range_mm, range_mm);
					fail_count++;
				end
				if (fail_substituted !== want.fail) begin
					$error("fail_substituted: expected %0d, actual %0d",
						want.fail, fail_substituted);
					fail_count++;
				end
			end
		end
	end

	// Test sequence
	initial begin
		int wait_cycles;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_frame_basics();
		test_register_extremes();
		test_random_traffic();
		// Drain the remaining results, then let the pipeline settle
		push <= 1'b0;
		wait_cycles = 0;
		while (ranges_due.size() != 0 && wait_cycles < 5000) begin
			@(posedge clk);
			wait_cycles++;
		end
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (ranges_due.size() != 0) begin
			$error("%0d expected results never arrived", ranges_due.size());
			fail_count++;
		end
		$display("Run covered %0d frame bytes, %0d valid frames and %0d checked range beats.",
			bytes_used, frames_passed, results_checked);
		$display("Settings swept alpha 0, 1, 256 and saturated, and several start markers.");
		if (fail_count == 0)
			$display("** ultrasonic_frame_filter_top: PASSED **");
		else
			$display("** ultrasonic_frame_filter_top: FAILED **");
		$finish;
	end

endmodule
